@@ design/fdst_pkg.sv @@
// Shared types and constants for the four-direction Sobel threshold block.
// No dependencies; imported by every module of the block.
`default_nettype none

package fdst_pkg;

   // pixel and arithmetic widths
   localparam int PIX_W      = 8;
   localparam int GRAD_W     = 11;   // |gradient| <= 4 * 255
   localparam int SQ_W       = 20;   // 1020^2 < 2^20
   localparam int SUM_W      = 22;   // four squares
   localparam int THR_SQ_W   = 16;

   // frame geometry
   localparam int MAX_HEIGHT = 1024;
   localparam int ROW_W      = 10;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int THR_W      = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 11'd480;
   localparam int THR_RESET = 100;
   localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(THR_RESET * THR_RESET);

   // result codes
   localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

   // 3x3 window, aRC = row R (0 top), column C (0 oldest)
   typedef struct packed {
      logic [PIX_W-1:0] a00;
      logic [PIX_W-1:0] a01;
      logic [PIX_W-1:0] a02;
      logic [PIX_W-1:0] a10;
      logic [PIX_W-1:0] a11;
      logic [PIX_W-1:0] a12;
      logic [PIX_W-1:0] a20;
      logic [PIX_W-1:0] a21;
      logic [PIX_W-1:0] a22;
   } win_type;

   // per-request control carried down the pipeline
   typedef struct packed {
      logic has_result;
      logic last;
   } tag_type;

endpackage

`default_nettype wire

@@ design/fdst_line_store.sv @@
// Two line stores (rows r-2 and r-1) in synchronous-read memories,
// with same-address forwarding and a zeroing sweep after reset. Uses fdst_pkg.
`default_nettype none

module fdst_line_store
   import fdst_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire logic [PIX_W-1:0] wr_upper,
   input  wire logic [PIX_W-1:0] wr_middle,
   output logic [PIX_W-1:0]      rd_upper,
   output logic [PIX_W-1:0]      rd_middle,
   output logic                  clear_busy
);

   logic [PIX_W-1:0] upper_mem [DEPTH];
   logic [PIX_W-1:0] middle_mem [DEPTH];

   logic [PIX_W-1:0] upper_q_ff, middle_q_ff;
   logic             fwd_ff, fwd_in;
   logic [PIX_W-1:0] fwd_upper_ff, fwd_middle_ff;
   logic             clr_ff, clr_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [PIX_W-1:0] mem_wu, mem_wm;

   // clearing sweep owns the write port until done
   always_comb begin
      if (clr_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_idx_ff;
         mem_wu = '0;
         mem_wm = '0;
      end else begin
         mem_we = wr_en;
         mem_wa = wr_idx;
         mem_wu = wr_upper;
         mem_wm = wr_middle;
      end
   end

   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         if (clr_idx_ff == IDX_W'(DEPTH - 1)) clr_in = 1'b0;
         else clr_idx_in = clr_idx_ff + 1'b1;
      end
   end

   // a read that meets a write to the same entry takes the write data
   assign fwd_in = wr_en && (wr_idx == rd_idx);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[mem_wa]  <= mem_wu;
         middle_mem[mem_wa] <= mem_wm;
      end
      if (rd_en) begin
         upper_q_ff  <= upper_mem[rd_idx];
         middle_q_ff <= middle_mem[rd_idx];
         fwd_upper_ff  <= wr_upper;
         fwd_middle_ff <= wr_middle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
         fwd_ff     <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
         if (rd_en) fwd_ff <= fwd_in;
      end
   end

   assign rd_upper   = fwd_ff ? fwd_upper_ff  : upper_q_ff;
   assign rd_middle  = fwd_ff ? fwd_middle_ff : middle_q_ff;
   assign clear_busy = clr_ff;

endmodule

`default_nettype wire

@@ design/fdst_grad_pipe.sv @@
// Gradient, square and threshold pipeline: four Sobel kernels, squares,
// sum and compare, ending in the result register. Uses fdst_pkg.
`default_nettype none

module fdst_grad_pipe
   import fdst_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire tag_type             in_tag,
   input  wire win_type             in_win,
   input  wire logic [THR_SQ_W-1:0] thr_sq,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [PIX_W-1:0]         out_edge,
   output logic                     out_last
);

   localparam int EXT_W = GRAD_W - PIX_W;

   // stage 2: gradients
   logic                     s2_v_ff, s2_v_in;
   tag_type                  s2_tag_ff;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff, g45_ff, g135_ff;
   // stage 3: squares
   logic                     s3_v_ff, s3_v_in;
   tag_type                  s3_tag_ff;
   logic [SQ_W-1:0]          sq_ff [4];
   // result register
   logic                     o_v_ff, o_v_in;
   logic [PIX_W-1:0]         o_edge_ff;
   logic                     o_last_ff;

   logic s2_go, s3_go, o_go;

   logic signed [GRAD_W-1:0] p00, p01, p02, p10, p12, p20, p21, p22;
   logic signed [GRAD_W-1:0] gx_in, gy_in, g45_in, g135_in;
   logic signed [2*GRAD_W-1:0] prod [4];
   logic [SUM_W-1:0]         sum;

   // stall chain; items without a result drop out of stage 3 freely
   assign o_go  = !o_v_ff || out_ready;
   assign s3_go = !s3_v_ff || !s3_tag_ff.has_result || o_go;
   assign s2_go = !s2_v_ff || s3_go;
   assign in_ready = s2_go;

   // kernels
   always_comb begin
      p00 = $signed({{EXT_W{1'b0}}, in_win.a00});
      p01 = $signed({{EXT_W{1'b0}}, in_win.a01});
      p02 = $signed({{EXT_W{1'b0}}, in_win.a02});
      p10 = $signed({{EXT_W{1'b0}}, in_win.a10});
      p12 = $signed({{EXT_W{1'b0}}, in_win.a12});
      p20 = $signed({{EXT_W{1'b0}}, in_win.a20});
      p21 = $signed({{EXT_W{1'b0}}, in_win.a21});
      p22 = $signed({{EXT_W{1'b0}}, in_win.a22});
      gx_in   = p00 - p02 + (p10 <<< 1) - (p12 <<< 1) + p20 - p22;
      gy_in   = p00 + (p01 <<< 1) + p02 - p20 - (p21 <<< 1) - p22;
      g45_in  = (p00 <<< 1) + p01 + p10 - p12 - p21 - (p22 <<< 1);
      g135_in = p10 - p01 - (p02 <<< 1) - p12 + (p20 <<< 1) + p21;
   end

   // squares
   always_comb begin
      prod[0] = gx_ff * gx_ff;
      prod[1] = gy_ff * gy_ff;
      prod[2] = g45_ff * g45_ff;
      prod[3] = g135_ff * g135_ff;
   end

   // sum of squares
   assign sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);

   always_comb begin
      s2_v_in = s2_go ? in_valid : s2_v_ff;
      s3_v_in = s3_go ? s2_v_ff  : s3_v_ff;
      o_v_in  = o_go  ? (s3_v_ff && s3_tag_ff.has_result) : o_v_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s2_tag_ff <= in_tag;
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         g45_ff    <= g45_in;
         g135_ff   <= g135_in;
      end
      if (s3_go) begin
         s3_tag_ff <= s2_tag_ff;
         for (int i = 0; i < 4; i++) sq_ff[i] <= prod[i][SQ_W-1:0];
      end
      if (o_go) begin
         o_edge_ff <= (sum > SUM_W'(thr_sq)) ? EDGE_ON : EDGE_OFF;
         o_last_ff <= s3_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
         o_v_ff  <= o_v_in;
      end
   end

   assign out_valid = o_v_ff;
   assign out_edge  = o_edge_ff;
   assign out_last  = o_last_ff;

endmodule

`default_nettype wire

@@ design/four_direction_sobel_threshold_top.sv @@
// Top level of the four-direction Sobel threshold block: configuration,
// position counters, line-store read stage and window. Uses fdst_pkg,
// fdst_line_store and fdst_grad_pipe.
//
//   channel  direction  tdata / data            tuser / index   tlast
//   req_     in         [7:0] pixel             [0] frame_start -
//   rsp_     out        [7:0] edge_pixel        -               last_of_frame
//   csr_     in (write) [10:0] register value   [1:0] register  -
//
// One pixel request is taken per clock while no stall or clearing pass holds req_tready;
// each result passes in turn: line-store read, gradients, squares, sum and compare.
// The line-store memory port is read and written once per cycle.
// After reset a clearing pass zeroes every entry of both line stores,
// with req_tready low; configuration writes are taken throughout.
// A stall on rsp_ holds the result and backs up into req_tready through the
// pipeline stages; a pixel without a result is dropped at the squares stage
// and never takes the result register.
`default_nettype none

module four_direction_sobel_threshold_top
   import fdst_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // pixel requests
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] pixel
   input  wire logic [0:0]            req_tuser,   // [0] frame_start
   // edge results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] edge_pixel
   output logic                       rsp_tlast,   // last_of_frame
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int XW    = 14;   // holds any register value and MAX_WIDTH

   // configuration
   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [THR_SQ_W-1:0]   thr_sq_ff;
   logic                  csr_wr;

   // position
   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;
   logic [XW-1:0]    width_x, height_x;
   tag_type          tag_cur;

   // read stage
   logic             accept, s1_go, s1_adv;
   logic             s1_v_ff, s1_v_in;
   logic [COL_W-1:0] s1_idx_ff;
   logic [PIX_W-1:0] s1_px_ff;
   tag_type          s1_tag_ff;
   logic [PIX_W-1:0] rd_upper, rd_middle;
   logic             clear_busy;
   logic             pipe_ready;

   // window columns c-2 and c-1
   logic [PIX_W-1:0] win_ff [6];
   win_type          win;

   // register writes
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thr_sq_ff <= THR_SQ_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT:   height_ff <= csr_data;
            CSR_EDGE_THRESHOLD:
               thr_sq_ff <= THR_SQ_W'(csr_data[THR_W-1:0]) * THR_SQ_W'(csr_data[THR_W-1:0]);
            default: ;
         endcase
      end
   end

   // effective last column and row, saturated to the legal geometry
   always_comb begin
      width_x  = XW'(width_ff);
      height_x = XW'(height_ff);
      if (width_x < XW'(3))               w_last = COL_W'(2);
      else if (width_x > XW'(MAX_WIDTH))  w_last = COL_W'(MAX_WIDTH - 1);
      else                                w_last = COL_W'(width_x - 1'b1);
      if (height_x < XW'(3))              h_last = ROW_W'(2);
      else if (height_x > XW'(MAX_HEIGHT)) h_last = ROW_W'(MAX_HEIGHT - 1);
      else                                h_last = ROW_W'(height_x - 1'b1);
   end

   // position of the incoming pixel and its result flags
   always_comb begin
      col_cur = req_tuser[0] ? '0 : col_ff;
      row_cur = req_tuser[0] ? '0 : row_ff;
      tag_cur.has_result = (row_cur >= ROW_W'(2)) && (row_cur <= h_last) &&
                           (col_cur >= COL_W'(2)) && (col_cur <= w_last);
      tag_cur.last = (row_cur == h_last) && (col_cur == w_last);
      if (col_cur >= w_last) begin
         col_in = '0;
         row_in = (row_cur >= h_last) ? '0 : row_cur + 1'b1;
      end else begin
         col_in = col_cur + 1'b1;
         row_in = row_cur;
      end
   end

   // handshake of the read stage
   assign s1_go      = !s1_v_ff || pipe_ready;
   assign s1_adv     = s1_v_ff && pipe_ready;
   assign req_tready = s1_go && !clear_busy;
   assign accept     = req_tvalid && req_tready;
   assign s1_v_in    = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff <= col_cur;
         s1_px_ff  <= req_tdata;
         s1_tag_ff <= tag_cur;
      end
   end

   // window shifts as each request leaves the read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= rd_upper;
         win_ff[4] <= rd_middle;
         win_ff[5] <= s1_px_ff;
      end
   end

   always_comb begin
      win.a00 = win_ff[0];
      win.a10 = win_ff[1];
      win.a20 = win_ff[2];
      win.a01 = win_ff[3];
      win.a11 = win_ff[4];
      win.a21 = win_ff[5];
      win.a02 = rd_upper;
      win.a12 = rd_middle;
      win.a22 = s1_px_ff;
   end

   // line stores: read on request, write back as the request moves on
   fdst_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_idx     (col_cur),
      .wr_en      (s1_adv),
      .wr_idx     (s1_idx_ff),
      .wr_upper   (rd_middle),
      .wr_middle  (s1_px_ff),
      .rd_upper   (rd_upper),
      .rd_middle  (rd_middle),
      .clear_busy (clear_busy)
   );

   fdst_grad_pipe u_grad_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_v_ff),
      .in_ready  (pipe_ready),
      .in_tag    (s1_tag_ff),
      .in_win    (win),
      .thr_sq    (thr_sq_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_edge  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ design/fdst_checker.sv @@
// Port-level checks for four_direction_sobel_threshold_top, bound to it below.
// Uses fdst_pkg for the result codes.
`default_nettype none

module fdst_checker
   import fdst_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // results are only the edge-on and edge-off codes
   a_edge_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == EDGE_ON || rsp_tdata == EDGE_OFF))
      else $error("edge result is neither on nor off");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // line-store clearing blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during line-store clearing");

   // no result leaves right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

endmodule

bind four_direction_sobel_threshold_top fdst_checker u_fdst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ test/four_direction_sobel_threshold_top_tb.sv @@
// Self-checking testbench for four_direction_sobel_threshold_top: streams frames of
// pixels, predicts each edge result and compares it with what the block returns.
// Depends on fdst_pkg and the design files under design/.
module four_direction_sobel_threshold_top_tb
   import fdst_pkg::*;
();

   localparam int IMG_MAX_WIDTH = 1024;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int STALL_LIMIT   = 4000;   // outlasts the line-store clearing pass after reset
   localparam int DRAIN_CYCLES  = 8;      // pipeline is four stages deep
   localparam int IDLE_PCT      = 28;
   localparam int REPORT_MAX    = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] edge_pixel;
      logic             last_of_frame;
   } edge_result_type;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
      logic             typed;
      logic [PIX_W-1:0] edge_pixel;
      logic             last_of_frame;
   } directed_row_type;

   typedef enum int {TEXTURE_RANDOM, TEXTURE_SMOOTH, TEXTURE_BINARY} texture_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] pixel
   logic [0:0]            req_tuser = '0;   // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // [7:0] edge_pixel
   logic                  rsp_tlast;        // last_of_frame
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state: configuration, line stores, window, position
   logic [CSR_DATA_W-1:0] cfg_width;
   logic [CSR_DATA_W-1:0] cfg_height;
   logic [THR_W-1:0]      cfg_threshold;
   logic [PIX_W-1:0]      upper_line [IMG_MAX_WIDTH];
   logic [PIX_W-1:0]      middle_line [IMG_MAX_WIDTH];
   logic [PIX_W-1:0]      window_cols [6];
   int                    col_pos;
   int                    row_pos;

   edge_result_type  expected_edges [$];
   directed_row_type directed_rows [29];

   // request-side bookkeeping for typed table rows
   logic             drv_typed = 1'b0;
   edge_result_type  drv_typed_result = '0;

   bit steady = 1'b0;
   bit in_random = 1'b0;
   int random_start;
   int pixels_sent;
   int results_checked;
   int edges_seen;
   int frames_closed;
   int csr_writes;
   int mismatches;
   int quiet_cycles;

   four_direction_sobel_threshold_top #(.MAX_WIDTH(IMG_MAX_WIDTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side backpressure
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic int clamp_dim(input logic [CSR_DATA_W-1:0] v, input int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   // Advances the position, line stores and window for one pixel and works out the edge
   // decision for the window it completes.
   function automatic void predict_edge(input logic [PIX_W-1:0] px, input logic fs,
                                        output logic has_result,
                                        output edge_result_type result);
      int w, h, c, r, thr;
      int a00, a01, a02, a10, a11, a12, a20, a21, a22;
      int gx, gy, g45, g135, energy;
      w = clamp_dim(cfg_width, IMG_MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;

      a00 = window_cols[0]; a10 = window_cols[1]; a20 = window_cols[2];
      a01 = window_cols[3]; a11 = window_cols[4]; a21 = window_cols[5];
      a02 = upper_line[c];
      a12 = middle_line[c];
      a22 = px;

      window_cols[0] = a01[7:0]; window_cols[1] = a11[7:0]; window_cols[2] = a21[7:0];
      window_cols[3] = a02[7:0]; window_cols[4] = a12[7:0]; window_cols[5] = px;
      upper_line[c]  = a12[7:0];
      middle_line[c] = px;

      gx   = a00 - a02 + 2 * a10 - 2 * a12 + a20 - a22;
      gy   = a00 + 2 * a01 + a02 - a20 - 2 * a21 - a22;
      g45  = 2 * a00 + a01 + a10 - a12 - a21 - 2 * a22;
      g135 = -a01 - 2 * a02 + a10 - a12 + 2 * a20 + a21;
      energy = gx * gx + gy * gy + g45 * g45 + g135 * g135;
      thr = cfg_threshold;

      has_result = (r >= 2) && (r <= h - 1) && (c >= 2) && (c <= w - 1);
      result.edge_pixel    = (energy > thr * thr) ? EDGE_ON : EDGE_OFF;
      result.last_of_frame = (r == h - 1) && (c == w - 1);

      // raster advance, wrapping at the frame end
      if (c >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic report_mismatch(input string what, input edge_result_type exp_r,
                                  input edge_result_type got_r);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s: expected edge_pixel %0d last %0b, got edge_pixel %0d last %0b",
                  $time, what, exp_r.edge_pixel, exp_r.last_of_frame,
                  got_r.edge_pixel, got_r.last_of_frame);
   endtask

   // Sample all three channels at the rising edge; results are checked before the
   // new request is predicted so a same-cycle pair never matches itself.
   always @(posedge clock) begin : monitor
      logic            has_result;
      edge_result_type predicted;
      edge_result_type got;
      edge_result_type want;
      bit              moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got.edge_pixel    = rsp_tdata;
            got.last_of_frame = rsp_tlast;
            if (expected_edges.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0, got);
            end else begin
               want = expected_edges.pop_front();
               results_checked++;
               if (got.edge_pixel != want.edge_pixel)
                  report_mismatch("edge_pixel", want, got);
               else if (got.last_of_frame != want.last_of_frame)
                  report_mismatch("last_of_frame", want, got);
               if (got.edge_pixel == EDGE_ON) edges_seen++;
               if (got.last_of_frame) frames_closed++;
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            predict_edge(req_tdata, req_tuser[0], has_result, predicted);
            if (has_result)
               expected_edges.push_back(drv_typed ? drv_typed_result : predicted);
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            csr_writes++;
            case (csr_index)
               CSR_IMAGE_WIDTH:    cfg_width = csr_data;
               CSR_IMAGE_HEIGHT:   cfg_height = csr_data;
               CSR_EDGE_THRESHOLD: cfg_threshold = csr_data[THR_W-1:0];
               default: ;
            endcase
         end
      end
      quiet_cycles = (moved || reset) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("four_direction_sobel_threshold_top_tb: done, errors");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one pixel request, with random gaps in front of it
   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs,
                             input logic typed, input edge_result_type typed_result);
      @(negedge clock);
      steady = in_random && (pixels_sent - random_start >= 500)
                         && (pixels_sent - random_start < 800);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid       <= 1'b1;
      req_tdata        <= px;
      req_tuser        <= fs;
      drv_typed        <= typed;
      drv_typed_result <= typed_result;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // stop sending and wait until every result is back and the pipeline is empty
   task automatic wait_idle;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(input texture_type tex, input bit fs_first, input int npix,
                             input int stray_fs_pct);
      int base, spread, v, i;
      logic fs;
      base   = $urandom_range(0, 255);
      spread = $urandom_range(0, 48);
      for (i = 0; i < npix; i++) begin
         case (tex)
            TEXTURE_SMOOTH: begin
               v = base + $urandom_range(0, spread) - spread / 2;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
            end
            TEXTURE_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
            default:        v = $urandom_range(0, 255);
         endcase
         fs = (i == 0 && fs_first) || ($urandom_range(99) < stray_fs_pct);
         send_pixel(v[7:0], fs, 1'b0, '0);
      end
   endtask

   // frame at one corner of the geometry, cut after max_pix pixels
   task automatic corner_frame(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                               input logic [CSR_DATA_W-1:0] thr, input texture_type tex,
                               input int max_pix);
      int npix;
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_EDGE_THRESHOLD, thr);
      npix = clamp_dim(cfg_width, IMG_MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
      if (npix > max_pix) npix = max_pix;
      send_frame(tex, 1'b1, npix, 0);
   endtask

   task automatic choose_settings;
      int pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 70) begin
         if (pick < 70)      csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(3, 12)));
         else if (pick < 88) csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(13, 40)));
         else                csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(0, 2)));
      end
      pick = $urandom_range(99);
      if ($urandom_range(99) < 70) begin
         if (pick < 88) csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(3, 8)));
         else           csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(0, 2)));
      end
      pick = $urandom_range(99);
      if ($urandom_range(99) < 70) begin
         // upper data bits are don't-care for the threshold register
         if (pick < 15)      csr_write(CSR_EDGE_THRESHOLD, {3'($urandom_range(0, 7)), 8'd0});
         else if (pick < 30) csr_write(CSR_EDGE_THRESHOLD, {3'($urandom_range(0, 7)), 8'd255});
         else                csr_write(CSR_EDGE_THRESHOLD,
                                       CSR_DATA_W'($urandom_range(0, 2047)));
      end
      if ($urandom_range(99) < 5)
         csr_write(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 2047)));
   endtask

   initial begin : stimulus
      int f, nframes, npix;
      bit cut_last, fs_first;
      edge_result_type typed_result;

      cfg_width     = WIDTH_RESET;
      cfg_height    = HEIGHT_RESET;
      cfg_threshold = THR_W'(THR_RESET);
      foreach (upper_line[k]) begin
         upper_line[k]  = '0;
         middle_line[k] = '0;
      end
      foreach (window_cols[k]) window_cols[k] = '0;
      col_pos = 0;
      row_pos = 0;

      // 3x3 frames: all-zero, top row bright without a frame start (counter wrap),
      // an aborted frame, then a checkerboard
      directed_rows = '{
         '{8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b1, EDGE_OFF, 1'b1},
         '{8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b1, EDGE_ON,  1'b1},
         '{8'd255, 1'b1, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b1, 1'b0, EDGE_OFF, 1'b0},
         '{8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd255, 1'b0, 1'b0, EDGE_OFF, 1'b0},
         '{8'd0,   1'b0, 1'b0, EDGE_OFF, 1'b0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest frame, threshold left at its reset value
      csr_write(CSR_IMAGE_WIDTH, 11'd3);
      csr_write(CSR_IMAGE_HEIGHT, 11'd3);
      csr_write(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 2047)));
      foreach (directed_rows[k]) begin
         typed_result.edge_pixel    = directed_rows[k].edge_pixel;
         typed_result.last_of_frame = directed_rows[k].last_of_frame;
         send_pixel(directed_rows[k].pixel, directed_rows[k].frame_start,
                    directed_rows[k].typed, typed_result);
      end

      // geometry corners, including out-of-range values that saturate
      corner_frame(11'd1024, 11'd3,    11'd0,    TEXTURE_SMOOTH, 120);
      corner_frame(11'd2047, 11'd0,    11'd255,  TEXTURE_BINARY, 120);
      corner_frame(11'd3,    11'd1024, 11'd60,   TEXTURE_SMOOTH, 200);
      corner_frame(11'd1,    11'd2047, 11'h7ff,  TEXTURE_RANDOM, 200);

      // random frames; some are cut short and resumed after settings are chosen anew
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 11'd8);
      csr_write(CSR_IMAGE_HEIGHT, 11'd6);
      in_random    = 1'b1;
      random_start = pixels_sent;
      cut_last     = 1'b0;
      while (pixels_sent - random_start < RANDOM_ITEMS) begin
         if (cut_last || $urandom_range(99) < 60) begin
            wait_idle();
            choose_settings();
         end
         nframes = $urandom_range(1, 3);
         for (f = 0; f < nframes; f++) begin
            if (pixels_sent - random_start >= RANDOM_ITEMS) break;
            fs_first = cut_last ? ($urandom_range(0, 1) != 0) : ($urandom_range(99) < 85);
            npix = clamp_dim(cfg_width, IMG_MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
            cut_last = ($urandom_range(99) < 20);
            if (cut_last) npix = $urandom_range(1, npix - 1);
            send_frame(texture_type'($urandom_range(0, 2)), fs_first, npix,
                       ($urandom_range(99) < 10) ? 3 : 0);
            if (cut_last) break;
         end
      end
      in_random = 1'b0;
      steady    = 1'b0;

      wait_idle();
      $display("sent %0d pixel requests and %0d register writes across corner and random frames",
               pixels_sent, csr_writes);
      $display("checked %0d edge results (%0d edges, %0d frame ends), %0d mismatches",
               results_checked, edges_seen, frames_closed, mismatches);
      if (mismatches == 0 && expected_edges.size() == 0) begin
         $display("four_direction_sobel_threshold_top_tb: done, clean");
      end else begin
         $display("four_direction_sobel_threshold_top_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/fdst_pkg.sv
design/fdst_line_store.sv
design/fdst_grad_pipe.sv
design/four_direction_sobel_threshold_top.sv
design/fdst_checker.sv
test/four_direction_sobel_threshold_top_tb.sv
